[design/nnbt_pkg.sv]
package nnbt_pkg;

	localparam int MAX_TRACKS_DEF = 64;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAD_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAD_FLOOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAD_CEIL   = 3'd4;

	localparam logic OP_DET = 1'b0;
	localparam logic OP_EOF = 1'b1;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_TRACK = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic [14:0] INV_PI_Q16 = 15'd20861;
	localparam logic [23:0] PATH_MAX   = 24'hFFFFFF;
	localparam logic [15:0] ID_MAX     = 16'hFFFF;

	localparam logic [15:0] RST_MATCH_DIST = 16'd800;
	localparam logic [7:0]  RST_MAX_AGE    = 8'd10;
	localparam logic [11:0] RST_RAD_GAIN   = 12'd320;
	localparam logic [15:0] RST_RAD_FLOOR  = 16'd320;
	localparam logic [15:0] RST_RAD_CEIL   = 16'd4800;

	localparam int SQ_OP_W   = 36;
	localparam int SQ_ROOT_W = SQ_OP_W / 2;
	localparam int SQ_REM_W  = SQ_ROOT_W + 2;
	localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

	typedef struct packed {
		logic        opcode;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [19:0] blob_area;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [15:0] track_id;
		logic [15:0] out_x;
		logic [15:0] out_y;
		logic [19:0] out_area;
		logic [15:0] hit_count;
		logic [7:0]  frames_unseen;
		logic [23:0] path_length;
		logic [15:0] display_radius;
		logic        created_new;
		logic        dropped_full;
		logic        last_record;
	} out_word_t;

	typedef struct packed {
		logic [15:0] max_match_distance;
		logic [7:0]  max_track_age;
		logic [11:0] radius_gain;
		logic [15:0] radius_floor;
		logic [15:0] radius_ceiling;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        hit_now;
		logic [15:0] id;
		logic [15:0] x;
		logic [15:0] y;
		logic [19:0] area;
		logic [15:0] hits;
		logic [7:0]  age;
		logic [23:0] path;
		logic [15:0] radius;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	typedef struct packed {
		logic clearing;
	} front_ctl_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DIST,
		ST_DIST_W,
		ST_AREA,
		ST_RAD,
		ST_RAD_W,
		ST_RMUL,
		ST_CLAMP,
		ST_FETCH,
		ST_FETCH_W,
		ST_UPDATE,
		ST_EF_RD,
		ST_EF_DATA,
		ST_EF_PROC,
		ST_EF_END
	} eng_state_t;

	function automatic out_word_t make_out(input logic [1:0] kind, input slot_rec_t rec,
			input logic created, input logic dropped, input logic last);
		out_word_t o;
		o.record_kind    = kind;
		o.track_id       = rec.id;
		o.out_x          = rec.x;
		o.out_y          = rec.y;
		o.out_area       = rec.area;
		o.hit_count      = rec.hits;
		o.frames_unseen  = rec.age;
		o.path_length    = rec.path;
		o.display_radius = rec.radius;
		o.created_new    = created;
		o.dropped_full   = dropped;
		o.last_record    = last;
		return o;
	endfunction

endpackage

[design/nnbt_ram.sv]
module nnbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[design/nnbt_isqrt.sv]
module nnbt_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [nnbt_pkg::SQ_OP_W-1:0]   operand,
	output logic                           done,
	output logic [nnbt_pkg::SQ_ROOT_W-1:0] root,
	output logic [nnbt_pkg::SQ_REM_W-1:0]  rem
);
	import nnbt_pkg::*;

	logic [SQ_OP_W-1:0]   op_q;
	logic [SQ_ROOT_W-1:0] root_q;
	logic [SQ_REM_W-1:0]  rem_q;
	logic [SQ_CNT_W-1:0]  cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SQ_REM_W-1:0]  rem_sh;
	logic [SQ_REM_W-1:0]  trial;
	logic                 fits;

	// one result bit per cycle, two operand bits consumed
	assign rem_sh = {rem_q[SQ_REM_W-3:0], op_q[SQ_OP_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CNT_W'(SQ_ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[SQ_OP_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[SQ_ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
	assign rem  = rem_q;
endmodule

[design/nnbt_front.sv]
module nnbt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  nnbt_pkg::in_word_t   in_word,
	input  nnbt_pkg::front_ctl_t ctl,
	output logic                 q_valid,
	output nnbt_pkg::in_word_t   q_word,
	input  logic                 q_pop
);
	import nnbt_pkg::*;

	in_word_t   ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2) || ctl.clearing;
	assign push     = in_valid && !in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_word   = ent_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (q_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= in_word;
		end
	end
endmodule

[design/nnbt_engine.sv]
module nnbt_engine #(
	parameter int MAX_TRACKS = nnbt_pkg::MAX_TRACKS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nnbt_pkg::cfg_t       cfg,
	input  logic                 q_valid,
	input  nnbt_pkg::in_word_t   q_word,
	output logic                 q_pop,
	output nnbt_pkg::front_ctl_t ctl,
	output logic                 out_valid,
	input  logic                 out_stall,
	output nnbt_pkg::out_word_t  out_word
);
	import nnbt_pkg::*;

	localparam int IW = $clog2(MAX_TRACKS);
	localparam logic [IW-1:0] LAST = IW'(MAX_TRACKS - 1);

	eng_state_t state_q, state_d;

	logic [IW-1:0] idx_q;
	logic          issuing_q;
	in_word_t      item_q;
	logic [32:0]   best_q;
	logic [IW-1:0] best_idx_q;
	logic          found_q;
	logic [IW-1:0] free_idx_q;
	logic          free_found_q;
	logic [31:0]   md2_q;
	logic [15:0]   next_id_q;

	logic          p0_v_q;
	logic [IW-1:0] p0_idx_q;
	logic          v_s1, sv_s1;
	logic [IW-1:0] idx_s1;
	logic [15:0]   dx_s1, dy_s1;
	logic          v_s2, sv_s2;
	logic [IW-1:0] idx_s2;
	logic [31:0]   dxx_s2, dyy_s2;

	logic [SQ_ROOT_W-1:0] path_inc_q;
	logic [34:0]          amul_q;
	logic [SQ_ROOT_W-1:0] s_q;
	logic [22:0]          rmul_q;
	logic [15:0]          radius_q;
	slot_rec_t            cur_q;
	slot_rec_t            pend_q;
	logic                 pend_v_q;

	out_word_t out_q, out_d;
	logic      out_v_q, out_load, out_free;

	logic             ram_we, ram_re;
	logic [IW-1:0]    ram_waddr, ram_raddr;
	logic [REC_W-1:0] ram_wdata, ram_rdata;
	slot_rec_t        rd_rec;

	logic                 sq_start, sq_done;
	logic [SQ_OP_W-1:0]   sq_op;
	logic [SQ_ROOT_W-1:0] sq_root;
	logic [SQ_REM_W-1:0]  sq_rem;

	logic [32:0] d2;
	logic        hit_s3, found_any, free_any;
	slot_rec_t   upd_rec, new_rec, ef_rec;
	logic [7:0]  age_n;
	logic        ef_surv, ef_hold;
	logic [24:0] path_sum;
	logic [29:0] rprod;
	logic [22:0] rad_lo, rad_hi;

	nnbt_ram #(.WIDTH(REC_W), .DEPTH(MAX_TRACKS)) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	nnbt_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.operand(sq_op),
		.done   (sq_done),
		.root   (sq_root),
		.rem    (sq_rem)
	);

	assign rd_rec   = slot_rec_t'(ram_rdata);
	assign out_free = !out_v_q || !out_stall;

	assign d2        = {1'b0, dxx_s2} + {1'b0, dyy_s2};
	assign hit_s3    = v_s2 && sv_s2 && (d2 < best_q);
	assign found_any = found_q || hit_s3;
	assign free_any  = free_found_q || (v_s2 && !sv_s2);

	assign path_sum = {1'b0, cur_q.path} + 25'(path_inc_q);
	assign rprod    = s_q * cfg.radius_gain;
	assign rad_lo   = (rmul_q < {7'b0, cfg.radius_floor}) ? {7'b0, cfg.radius_floor} : rmul_q;
	assign rad_hi   = (rad_lo > {7'b0, cfg.radius_ceiling}) ? {7'b0, cfg.radius_ceiling} : rad_lo;

	always_comb begin
		upd_rec         = cur_q;
		upd_rec.valid   = 1'b1;
		upd_rec.hit_now = 1'b1;
		upd_rec.x       = item_q.pos_x;
		upd_rec.y       = item_q.pos_y;
		upd_rec.area    = item_q.blob_area;
		upd_rec.hits    = (cur_q.hits == 16'hFFFF) ? cur_q.hits : cur_q.hits + 16'd1;
		upd_rec.age     = '0;
		upd_rec.path    = path_sum[24] ? PATH_MAX : path_sum[23:0];
		upd_rec.radius  = radius_q;

		new_rec.valid   = 1'b1;
		new_rec.hit_now = 1'b1;
		new_rec.id      = next_id_q;
		new_rec.x       = item_q.pos_x;
		new_rec.y       = item_q.pos_y;
		new_rec.area    = item_q.blob_area;
		new_rec.hits    = 16'd1;
		new_rec.age     = '0;
		new_rec.path    = '0;
		new_rec.radius  = radius_q;

		age_n   = (!cur_q.hit_now && cur_q.age != 8'hFF) ? cur_q.age + 8'd1 : cur_q.age;
		ef_surv = cur_q.valid && (age_n <= cfg.max_track_age);
		ef_rec         = cur_q;
		ef_rec.age     = age_n;
		ef_rec.valid   = ef_surv;
		ef_rec.hit_now = 1'b0;
		ef_hold = ef_surv && pend_v_q && !out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		out_load  = 1'b0;
		out_d     = '0;
		q_pop     = 1'b0;
		sq_start  = 1'b0;
		sq_op     = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (idx_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = (q_word.opcode == OP_EOF) ? ST_EF_RD : ST_SCAN;
				end
			end
			ST_SCAN: begin
				ram_re = issuing_q;
				if (v_s2 && idx_s2 == LAST) begin
					state_d = found_any ? ST_DIST : (free_any ? ST_AREA : ST_UPDATE);
				end
			end
			ST_DIST: begin
				sq_start = 1'b1;
				sq_op    = SQ_OP_W'(best_q);
				state_d  = ST_DIST_W;
			end
			ST_DIST_W: begin
				if (sq_done) begin
					state_d = ST_AREA;
				end
			end
			ST_AREA: begin
				state_d = ST_RAD;
			end
			ST_RAD: begin
				sq_start = 1'b1;
				sq_op    = SQ_OP_W'(amul_q);
				state_d  = ST_RAD_W;
			end
			ST_RAD_W: begin
				if (sq_done) begin
					state_d = ST_RMUL;
				end
			end
			ST_RMUL: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				state_d = found_q ? ST_FETCH : ST_UPDATE;
			end
			ST_FETCH: begin
				ram_re    = 1'b1;
				ram_raddr = best_idx_q;
				state_d   = ST_FETCH_W;
			end
			ST_FETCH_W: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (found_q) begin
						ram_we    = 1'b1;
						ram_waddr = best_idx_q;
						ram_wdata = upd_rec;
						out_d     = make_out(KIND_REPLY, upd_rec, 1'b0, 1'b0, 1'b1);
					end else if (free_found_q) begin
						ram_we    = 1'b1;
						ram_waddr = free_idx_q;
						ram_wdata = new_rec;
						out_d     = make_out(KIND_REPLY, new_rec, 1'b1, 1'b0, 1'b1);
					end else begin
						out_d = make_out(KIND_REPLY, '0, 1'b0, 1'b1, 1'b1);
					end
				end
			end
			ST_EF_RD: begin
				ram_re  = 1'b1;
				state_d = ST_EF_DATA;
			end
			ST_EF_DATA: begin
				state_d = ST_EF_PROC;
			end
			ST_EF_PROC: begin
				if (!ef_hold) begin
					ram_we    = 1'b1;
					ram_wdata = ef_rec;
					if (ef_surv && pend_v_q) begin
						out_load = 1'b1;
						out_d    = make_out(KIND_TRACK, pend_q, 1'b0, 1'b0, 1'b0);
					end
					state_d = (idx_q == LAST) ? ST_EF_END : ST_EF_RD;
				end
			end
			ST_EF_END: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (pend_v_q) begin
						out_d = make_out(KIND_TRACK, pend_q, 1'b0, 1'b0, 1'b1);
					end else begin
						out_d = make_out(KIND_EMPTY, '0, 1'b0, 1'b0, 1'b1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			issuing_q    <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			pend_v_q     <= 1'b0;
			next_id_q    <= 16'd1;
			out_v_q      <= 1'b0;
			p0_v_q       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			p0_v_q  <= (state_q == ST_SCAN) && issuing_q;
			v_s1    <= p0_v_q;
			v_s2    <= v_s1;
			out_v_q <= out_load || (out_v_q && out_stall);
			case (state_q)
				ST_CLEAR: begin
					idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
				end
				ST_IDLE: begin
					if (q_valid) begin
						idx_q        <= '0;
						issuing_q    <= q_word.opcode == OP_DET;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						pend_v_q     <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						if (idx_q == LAST) begin
							issuing_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (hit_s3) begin
						found_q <= 1'b1;
					end
					if (v_s2 && !sv_s2) begin
						free_found_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					if (out_free && !found_q && free_found_q) begin
						next_id_q <= (next_id_q == ID_MAX) ? 16'd1 : next_id_q + 16'd1;
					end
				end
				ST_EF_PROC: begin
					if (!ef_hold) begin
						idx_q <= (idx_q == LAST) ? '0 : idx_q + 1'b1;
						if (ef_surv) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				ST_EF_END: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		md2_q    <= cfg.max_match_distance * cfg.max_match_distance;
		p0_idx_q <= idx_q;
		idx_s1   <= p0_idx_q;
		sv_s1    <= rd_rec.valid;
		dx_s1    <= (rd_rec.x > item_q.pos_x) ? rd_rec.x - item_q.pos_x
			: item_q.pos_x - rd_rec.x;
		dy_s1    <= (rd_rec.y > item_q.pos_y) ? rd_rec.y - item_q.pos_y
			: item_q.pos_y - rd_rec.y;
		idx_s2   <= idx_s1;
		sv_s2    <= sv_s1;
		dxx_s2   <= dx_s1 * dx_s1;
		dyy_s2   <= dy_s1 * dy_s1;
		if (out_load) begin
			out_q <= out_d;
		end
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					item_q <= q_word;
					best_q <= {1'b0, md2_q};
				end
			end
			ST_SCAN: begin
				if (hit_s3) begin
					best_q     <= d2;
					best_idx_q <= idx_s2;
				end
				if (v_s2 && !sv_s2 && !free_found_q) begin
					free_idx_q <= idx_s2;
				end
			end
			ST_DIST_W: begin
				if (sq_done) begin
					path_inc_q <= sq_root + SQ_ROOT_W'(sq_rem > {2'b00, sq_root});
				end
			end
			ST_AREA: begin
				amul_q <= item_q.blob_area * INV_PI_Q16;
			end
			ST_RAD_W: begin
				if (sq_done) begin
					s_q <= sq_root;
				end
			end
			ST_RMUL: begin
				rmul_q <= 23'(({1'b0, rprod} + 31'd128) >> 8);
			end
			ST_CLAMP: begin
				radius_q <= rad_hi[15:0];
			end
			ST_FETCH_W: begin
				cur_q <= rd_rec;
			end
			ST_EF_DATA: begin
				cur_q <= rd_rec;
			end
			ST_EF_PROC: begin
				if (!ef_hold && ef_surv) begin
					pend_q <= ef_rec;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.clearing = state_q == ST_CLEAR;
	assign out_valid    = out_v_q;
	assign out_word     = out_q;
endmodule

[design/nearest_neighbor_blob_tracker.sv]
// channel  | valid     | stall     | word
// ---------+-----------+-----------+-------------------------------------
// input    | in_valid  | in_stall  | in_word  (detection / end of frame)
// output   | out_valid | out_stall | out_word (reply / track / empty)
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// detection: a scan over all MAX_TRACKS slots, then sqrt work unless dropped:
//   one slot read per cycle through a three-stage distance pipe, then passes
//   of the shared sqrt unit (path step when matched, then radius)
// end of frame: slots read, latched, written back; a record per live track, or one empty
// after reset a clearing pass over all MAX_TRACKS slots holds in_stall high
// a two-word input queue and the output register let each side stall alone
module nearest_neighbor_blob_tracker #(
	parameter int MAX_TRACKS = nnbt_pkg::MAX_TRACKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  nnbt_pkg::in_word_t                  in_word,
	output logic                                out_valid,
	input  logic                                out_stall,
	output nnbt_pkg::out_word_t                 out_word,
	input  logic                                cfg_we,
	input  logic [nnbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nnbt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import nnbt_pkg::*;

	cfg_t       cfg_q;
	front_ctl_t ctl;
	logic       q_valid;
	in_word_t   q_word;
	logic       q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_match_distance <= RST_MATCH_DIST;
			cfg_q.max_track_age      <= RST_MAX_AGE;
			cfg_q.radius_gain        <= RST_RAD_GAIN;
			cfg_q.radius_floor       <= RST_RAD_FLOOR;
			cfg_q.radius_ceiling     <= RST_RAD_CEIL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MATCH_DIST: cfg_q.max_match_distance <= cfg_data;
				CFG_MAX_AGE:    cfg_q.max_track_age      <= cfg_data[7:0];
				CFG_RAD_GAIN:   cfg_q.radius_gain        <= cfg_data[11:0];
				CFG_RAD_FLOOR:  cfg_q.radius_floor       <= cfg_data;
				CFG_RAD_CEIL:   cfg_q.radius_ceiling     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	nnbt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word (in_word),
		.ctl     (ctl),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_pop   (q_pop)
	);

	nnbt_engine #(.MAX_TRACKS(MAX_TRACKS)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.q_pop    (q_pop),
		.ctl      (ctl),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	a_drop_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.dropped_full |-> out_word.track_id == 16'd0
			&& !out_word.created_new && out_word.last_record)
		else $error("dropped reply carries a track");

	a_new_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.created_new |-> out_word.hit_count == 16'd1
			&& out_word.path_length == 24'd0 && out_word.track_id != 16'd0)
		else $error("new track not fresh");

	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.record_kind == KIND_REPLY
			|| out_word.record_kind == KIND_EMPTY) |-> out_word.last_record)
		else $error("single-word result not marked last");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> !q_pop && in_stall)
		else $error("item taken during clearing pass");
endmodule

[tb/nnbt_checker.sv]
`timescale 1ns / 1ps

module nnbt_checker
	import nnbt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_word_t              in_word,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_word_t             out_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);

	localparam int NSLOT = MAX_TRACKS_DEF;

	cfg_t        cfg;
	slot_rec_t   trk [NSLOT];
	logic [15:0] next_id;
	out_word_t   expected_q [$];
	int          n_words;

	task automatic queue_word(input out_word_t w);
		expected_q.insert(expected_q.size(), w);
	endtask

	function automatic logic [63:0] int_root(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] blob_radius(input logic [19:0] area);
		logic [63:0] s;
		logic [63:0] r;
		s = int_root(64'(area) * 64'd20861);
		r = (s * 64'(cfg.radius_gain) + 64'd128) >> 8;
		if (r < 64'(cfg.radius_floor))
			r = 64'(cfg.radius_floor);
		if (r > 64'(cfg.radius_ceiling))
			r = 64'(cfg.radius_ceiling);
		return r[15:0];
	endfunction

	function automatic out_word_t track_word(input logic [1:0] kind, input int s,
			input logic created, input logic dropped, input logic last);
		out_word_t w;
		w = '0;
		w.record_kind = kind;
		if (s >= 0) begin
			w.track_id       = trk[s].id;
			w.out_x          = trk[s].x;
			w.out_y          = trk[s].y;
			w.out_area       = trk[s].area;
			w.hit_count      = trk[s].hits;
			w.frames_unseen  = trk[s].age;
			w.path_length    = trk[s].path;
			w.display_radius = trk[s].radius;
		end
		w.created_new  = created;
		w.dropped_full = dropped;
		w.last_record  = last;
		return w;
	endfunction

	task automatic associate(input in_word_t w);
		logic [63:0] best_d2;
		logic [63:0] dx;
		logic [63:0] dy;
		logic [63:0] d2;
		logic [63:0] step;
		logic [63:0] p;
		int          best;
		int          free_s;
		best_d2 = 64'(cfg.max_match_distance) * 64'(cfg.max_match_distance);
		best = -1;
		free_s = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (trk[i].valid) begin
				dx = trk[i].x > w.pos_x ? 64'(trk[i].x - w.pos_x) : 64'(w.pos_x - trk[i].x);
				dy = trk[i].y > w.pos_y ? 64'(trk[i].y - w.pos_y) : 64'(w.pos_y - trk[i].y);
				d2 = dx * dx + dy * dy;
				if (d2 < best_d2) begin
					best_d2 = d2;
					best = i;
				end
			end else if (free_s < 0) begin
				free_s = i;
			end
		end
		if (best >= 0) begin
			step = int_root(best_d2);
			if (best_d2 > step * step + step)
				step = step + 1;
			p = 64'(trk[best].path) + step;
			trk[best].path   = p > 64'(PATH_MAX) ? PATH_MAX : p[23:0];
			trk[best].x      = w.pos_x;
			trk[best].y      = w.pos_y;
			trk[best].area   = w.blob_area;
			if (trk[best].hits != 16'hFFFF)
				trk[best].hits = trk[best].hits + 1;
			trk[best].age     = 0;
			trk[best].hit_now = 1;
			trk[best].radius  = blob_radius(w.blob_area);
			queue_word(track_word(KIND_REPLY, best, 0, 0, 1));
		end else if (free_s >= 0) begin
			trk[free_s].valid   = 1;
			trk[free_s].id      = next_id;
			next_id = (next_id == ID_MAX) ? 16'd1 : next_id + 16'd1;
			trk[free_s].x       = w.pos_x;
			trk[free_s].y       = w.pos_y;
			trk[free_s].area    = w.blob_area;
			trk[free_s].hits    = 1;
			trk[free_s].age     = 0;
			trk[free_s].path    = 0;
			trk[free_s].hit_now = 1;
			trk[free_s].radius  = blob_radius(w.blob_area);
			queue_word(track_word(KIND_REPLY, free_s, 1, 0, 1));
		end else begin
			queue_word(track_word(KIND_REPLY, -1, 0, 1, 1));
		end
	endtask

	task automatic close_frame();
		int n;
		n = 0;
		for (int i = 0; i < NSLOT; i++) begin
			if (trk[i].valid) begin
				if (!trk[i].hit_now && trk[i].age != 8'hFF)
					trk[i].age = trk[i].age + 1;
				if (trk[i].age > cfg.max_track_age)
					trk[i].valid = 0;
			end
			trk[i].hit_now = 0;
		end
		for (int i = 0; i < NSLOT; i++) begin
			if (trk[i].valid) begin
				queue_word(track_word(KIND_TRACK, i, 0, 0, 0));
				n++;
			end
		end
		if (n == 0)
			queue_word(track_word(KIND_EMPTY, -1, 0, 0, 1));
		else
			expected_q[$].last_record = 1;
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("[%0t] word %0d: %s got 0x%0h expected 0x%0h", $time, n_words, what, got, want);
		mismatches = mismatches + 1;
	endtask

	task automatic check_word(input out_word_t g);
		out_word_t e;
		e = expected_q.pop_front();
		if (g.record_kind !== e.record_kind)
			report("record_kind", 32'(g.record_kind), 32'(e.record_kind));
		if (g.track_id !== e.track_id)
			report("track_id", 32'(g.track_id), 32'(e.track_id));
		if (g.out_x !== e.out_x)
			report("out_x", 32'(g.out_x), 32'(e.out_x));
		if (g.out_y !== e.out_y)
			report("out_y", 32'(g.out_y), 32'(e.out_y));
		if (g.out_area !== e.out_area)
			report("out_area", 32'(g.out_area), 32'(e.out_area));
		if (g.hit_count !== e.hit_count)
			report("hit_count", 32'(g.hit_count), 32'(e.hit_count));
		if (g.frames_unseen !== e.frames_unseen)
			report("frames_unseen", 32'(g.frames_unseen), 32'(e.frames_unseen));
		if (g.path_length !== e.path_length)
			report("path_length", 32'(g.path_length), 32'(e.path_length));
		if (g.display_radius !== e.display_radius)
			report("display_radius", 32'(g.display_radius), 32'(e.display_radius));
		if (g.created_new !== e.created_new)
			report("created_new", 32'(g.created_new), 32'(e.created_new));
		if (g.dropped_full !== e.dropped_full)
			report("dropped_full", 32'(g.dropped_full), 32'(e.dropped_full));
		if (g.last_record !== e.last_record)
			report("last_record", 32'(g.last_record), 32'(e.last_record));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.max_match_distance = RST_MATCH_DIST;
			cfg.max_track_age      = RST_MAX_AGE;
			cfg.radius_gain        = RST_RAD_GAIN;
			cfg.radius_floor       = RST_RAD_FLOOR;
			cfg.radius_ceiling     = RST_RAD_CEIL;
			for (int i = 0; i < NSLOT; i++)
				trk[i] = '0;
			next_id = 16'd1;
			expected_q.delete();
			n_words = 0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MATCH_DIST: cfg.max_match_distance = cfg_data;
					CFG_MAX_AGE:    cfg.max_track_age      = cfg_data[7:0];
					CFG_RAD_GAIN:   cfg.radius_gain        = cfg_data[11:0];
					CFG_RAD_FLOOR:  cfg.radius_floor       = cfg_data;
					CFG_RAD_CEIL:   cfg.radius_ceiling     = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (in_word.opcode == OP_DET)
					associate(in_word);
				else
					close_frame();
			end
			if (out_valid && !out_stall) begin
				n_words++;
				if (expected_q.size() == 0)
					report("unexpected word, kind", 32'(out_word.record_kind), 32'hFFFFFFFF);
				else
					check_word(out_word);
			end
			pending <= expected_q.size();
		end
	end

endmodule

[tb/nearest_neighbor_blob_tracker_tb.sv]
`timescale 1ns / 1ps

module nearest_neighbor_blob_tracker_tb;
	import nnbt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_word_t              in_word;
	logic                  out_valid;
	logic                  out_stall;
	out_word_t             out_word;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;

	logic        idle_on;
	logic        hold_req;
	int          n_det;
	int          n_eof;
	int          n_cfg;
	logic [15:0] cx [8];
	logic [15:0] cy [8];

	nearest_neighbor_blob_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nnbt_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d words outstanding", pending);
		$display("Mismatches found");
		$finish;
	end

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int held;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1;
				for (held = 0; held < 800; held++)
					@(posedge clk);
				hold_req = 0;
			end
			out_stall <= idle_on && ($urandom_range(99) < 36);
		end
	end

	task automatic send(input in_word_t w);
		while (idle_on && $urandom_range(99) < 36) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (w.opcode == OP_DET)
			n_det++;
		else
			n_eof++;
	endtask

	task automatic detect(input logic [15:0] x, input logic [15:0] y, input logic [19:0] a);
		in_word_t w;
		w.opcode    = OP_DET;
		w.pos_x     = x;
		w.pos_y     = y;
		w.blob_area = a;
		send(w);
	endtask

	task automatic end_frame();
		in_word_t w;
		w.opcode    = OP_EOF;
		w.pos_x     = 16'($urandom);
		w.pos_y     = 16'($urandom);
		w.blob_area = 20'($urandom);
		send(w);
	endtask

	task automatic drain();
		in_valid <= 0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] gate, input logic [15:0] age,
			input logic [15:0] gain, input logic [15:0] lo, input logic [15:0] hi);
		drain();
		set_reg(CFG_MATCH_DIST, gate);
		set_reg(CFG_MAX_AGE, age);
		set_reg(CFG_RAD_GAIN, gain);
		set_reg(CFG_RAD_FLOOR, lo);
		set_reg(CFG_RAD_CEIL, hi);
		cfg_we <= 0;
		n_cfg++;
	endtask

	function automatic logic [15:0] pick16(input logic [15:0] lo, input logic [15:0] hi);
		case ($urandom_range(3))
			0:       return lo;
			1:       return hi;
			default: return 16'($urandom_range(hi, lo));
		endcase
	endfunction

	initial begin
		int jx;
		int jy;
		arst_n    = 0;
		in_valid  = 0;
		in_word   = '0;
		cfg_we    = 0;
		cfg_index = CFG_MATCH_DIST;
		cfg_data  = '0;
		idle_on   = 1;
		hold_req  = 0;
		n_det = 0;
		n_eof = 0;
		n_cfg = 0;
		repeat (5) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// reset settings: empty list, extremes, match, tie
		end_frame();
		detect(16'd0, 16'd0, 20'd0);
		detect(16'hFFFF, 16'hFFFF, 20'hFFFFF);
		detect(16'd10, 16'd10, 20'd5);
		detect(16'd2000, 16'd2000, 20'd300);
		detect(16'd3000, 16'd2000, 20'd301);
		detect(16'd2500, 16'd2000, 20'd77);
		end_frame();
		end_frame();

		// zero gate, inverted radius limits, masked age write, unused index
		drain();
		set_reg(CFG_UNUSED, 16'hFFFF);
		configure(16'd0, 16'hFF00, 16'hFFFF, 16'd5000, 16'd100);
		for (int i = 0; i < 66; i++)
			detect(16'($urandom), 16'($urandom), 20'($urandom));
		end_frame();
		end_frame();
		end_frame();

		// long moves on one track, then aging under the widest age limit
		configure(16'hFFFF, 16'd255, 16'd4095, 16'd0, 16'hFFFF);
		for (int i = 0; i < 20; i++)
			detect((i % 2) ? 16'd65534 : 16'd0, 16'd0, 20'($urandom));
		for (int i = 0; i < 12; i++)
			end_frame();
		configure(16'd800, 16'd0, 16'd320, 16'd320, 16'd4800);
		end_frame();
		end_frame();

		// random frames around moving centers
		for (int c = 0; c < 4; c++) begin
			configure(pick16(16'd0, 16'hFFFF), pick16(16'd0, 16'd20),
				pick16(16'd0, 16'd4095), pick16(16'd0, 16'hFFFF), pick16(16'd0, 16'hFFFF));
			if ($urandom_range(1))
				configure(16'($urandom_range(3000, 200)), 16'($urandom_range(12, 1)),
					16'($urandom_range(4095)), 16'($urandom_range(600)),
					16'($urandom_range(65535, 600)));
			for (int k = 0; k < 8; k++) begin
				cx[k] = 16'($urandom);
				cy[k] = 16'($urandom);
			end
			idle_on = (c != 2);
			if (c == 1)
				hold_req = 1;
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(99) < 20) begin
					end_frame();
				end else if ($urandom_range(99) < 85) begin
					int k;
					k = $urandom_range(7);
					jx = $urandom_range(600);
					jy = $urandom_range(600);
					cx[k] = cx[k] + 16'(jx - 300);
					cy[k] = cy[k] + 16'(jy - 300);
					detect(cx[k], cy[k], 20'($urandom_range(20000)));
				end else begin
					detect(16'($urandom), 16'($urandom), 20'($urandom));
				end
			end
			end_frame();
			idle_on = 1;
		end

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d detections and %0d end-of-frame words over %0d register settings",
			n_det, n_eof, n_cfg);
		$display("including a full table, long moves, aging, and a long output hold-off");
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[nearest_neighbor_blob_tracker.f]
design/nnbt_pkg.sv
design/nnbt_ram.sv
design/nnbt_isqrt.sv
design/nnbt_front.sv
design/nnbt_engine.sv
design/nearest_neighbor_blob_tracker.sv
tb/nnbt_checker.sv
tb/nearest_neighbor_blob_tracker_tb.sv
